// ----- rtl/core/joystick_event_direction_trigger_top_macros.svh -----
// Assertion macros for the joystick event direction and trigger block.
// Included by rtl/core modules that carry concurrent checks; no dependencies.
`ifndef JOYSTICK_EVENT_DIRECTION_TRIGGER_TOP_MACROS_SVH
`define JOYSTICK_EVENT_DIRECTION_TRIGGER_TOP_MACROS_SVH

// check that cons holds in the same cycle as ante
`define JEDT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// check that cons holds in the cycle after ante
`define JEDT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/core/jedt_pkg.sv -----
// Shared types and constants for the joystick event direction and trigger block.
// No dependencies; imported by jedt_csr, jedt_serial_div and the top level.
`timescale 1ns / 1ps

package jedt_pkg;

   localparam int SAMPLE_W = 16;
   localparam int LINE_W   = 2;
   localparam int THR_W    = 17;
   localparam int QUO_W    = 17;
   localparam int NUM_W    = 8;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   localparam logic [1:0] KIND_BUTTON = 2'd0;
   localparam logic [1:0] KIND_AXIS   = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] DEFLECT_NEG = 16'sh8001;
   localparam logic signed [SAMPLE_W-1:0] DEFLECT_POS = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] DEFLECT_NONE = 16'sh0000;

   typedef enum logic [2:0] {
      REG_UP_LINE      = 3'd0,
      REG_DOWN_LINE    = 3'd1,
      REG_LEFT_LINE    = 3'd2,
      REG_RIGHT_LINE   = 3'd3,
      REG_TRIGGER_AXIS = 3'd4,
      REG_CALIB_AXIS   = 3'd5,
      REG_THRESHOLD    = 3'd6,
      REG_INVERT       = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [LINE_W-1:0]       up_line;
      logic [LINE_W-1:0]       down_line;
      logic [LINE_W-1:0]       left_line;
      logic [LINE_W-1:0]       right_line;
      logic [LINE_W-1:0]       trigger_axis;
      logic [LINE_W-1:0]       calib_axis;
      logic signed [THR_W-1:0] trigger_threshold;
      logic                    invert_trigger;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      up_line:           2'd2,
      down_line:         2'd0,
      left_line:         2'd3,
      right_line:        2'd1,
      trigger_axis:      2'd0,
      calib_axis:        2'd1,
      trigger_threshold: 17'sd16384,
      invert_trigger:    1'b0
   };

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [1:0] {
      ST_IDLE     = 2'd0,
      ST_CAL_RUN  = 2'd1,
      ST_TRIG_RUN = 2'd2,
      ST_EMIT     = 2'd3
   } state_type;

endpackage

// ----- rtl/core/joystick_event_direction_trigger_top.sv -----
// Top level of the joystick event direction and trigger block.
// Depends on jedt_pkg, jedt_csr and jedt_serial_div.
`timescale 1ns / 1ps
`include "joystick_event_direction_trigger_top_macros.svh"

// A button or axis transaction is absorbed on acceptance and gives no result. A frame
// tick gives one result: the calibration and trigger averages both go through one shared
// bit-serial divider that yields one quotient bit per cycle, calibration first. No
// transaction is taken while a tick is in progress; a finished result waits in the
// output register.

module joystick_event_direction_trigger_top
   import jedt_pkg::*;
#(
   parameter int MAX_SAMPLES_PER_FRAME = 255
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_kind,
   input  logic [NUM_W-1:0]           req_source_number,
   input  logic signed [SAMPLE_W-1:0] req_event_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_delta_x,
   output logic signed [SAMPLE_W-1:0] rsp_delta_y,
   output logic                       rsp_fire,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_AW-1:0]          csr_paddr,
   input  logic [CSR_DW-1:0]          csr_pwdata,
   output logic [CSR_DW-1:0]          csr_prdata,
   output logic                       csr_pready
);

   localparam int CNT_W = $clog2(MAX_SAMPLES_PER_FRAME + 1);
   localparam int SUM_W = SAMPLE_W + CNT_W;

   cfg_type        cfg;
   div_status_type div_status;
   logic signed [QUO_W-1:0] div_quotient;
   logic                    div_start;
   logic signed [SUM_W-1:0] div_dividend;
   logic [CNT_W-1:0]        div_divisor;

   state_type state_ff, state_in;

   logic flag_up_ff, flag_up_in;
   logic flag_down_ff, flag_down_in;
   logic flag_left_ff, flag_left_in;
   logic flag_right_ff, flag_right_in;
   logic fire_ff, fire_in;
   logic signed [SAMPLE_W-1:0] offset_ff, offset_in;
   logic signed [SUM_W-1:0]    trig_sum_ff, trig_sum_in;
   logic signed [SUM_W-1:0]    cal_sum_ff, cal_sum_in;
   logic [CNT_W-1:0]           trig_cnt_ff, trig_cnt_in;
   logic [CNT_W-1:0]           cal_cnt_ff, cal_cnt_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] dx_ff, dx_in;
   logic signed [SAMPLE_W-1:0] dy_ff, dy_in;
   logic                       rsp_fire_ff, rsp_fire_in;

   logic accept;
   logic load_out;
   logic pressed;
   logic num_hi_zero;
   logic signed [SUM_W-1:0] sample_ext;
   logic signed [QUO_W:0]   cal_diff;
   logic signed [QUO_W:0]   thr_ext;
   logic                    above;

   jedt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   jedt_serial_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign accept      = req_valid & req_ready;
   assign pressed     = |req_event_value;
   assign num_hi_zero = ~|req_source_number[NUM_W-1:LINE_W];
   assign sample_ext  = {{(SUM_W-SAMPLE_W){req_event_value[SAMPLE_W-1]}}, req_event_value};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_TICK) begin
               state_in = ST_CAL_RUN;
            end
         end
         ST_CAL_RUN: begin
            if (div_status.done) begin
               state_in = ST_TRIG_RUN;
            end
         end
         ST_TRIG_RUN: begin
            if (div_status.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // state machine outputs
   always_comb begin
      req_ready    = 1'b0;
      div_start    = 1'b0;
      load_out     = 1'b0;
      div_dividend = cal_sum_ff;
      div_divisor  = cal_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            div_start = req_valid && req_kind == KIND_TICK;
         end
         ST_CAL_RUN: begin
            div_start    = div_status.done;
            div_dividend = trig_sum_ff;
            div_divisor  = trig_cnt_ff;
         end
         ST_TRIG_RUN: begin
            div_dividend = trig_sum_ff;
            div_divisor  = trig_cnt_ff;
         end
         ST_EMIT: begin
            load_out = !rsp_valid_ff || rsp_ready;
         end
      endcase
   end

   assign cal_diff = {div_quotient[QUO_W-1], div_quotient}
                   - {{(QUO_W+1-SAMPLE_W){offset_ff[SAMPLE_W-1]}}, offset_ff};
   assign thr_ext  = {cfg.trigger_threshold[THR_W-1], cfg.trigger_threshold};
   assign above    = cal_diff > thr_ext;

   // datapath
   always_comb begin
      flag_up_in    = flag_up_ff;
      flag_down_in  = flag_down_ff;
      flag_left_in  = flag_left_ff;
      flag_right_in = flag_right_ff;
      fire_in       = fire_ff;
      offset_in     = offset_ff;
      trig_sum_in   = trig_sum_ff;
      trig_cnt_in   = trig_cnt_ff;
      cal_sum_in    = cal_sum_ff;
      cal_cnt_in    = cal_cnt_ff;

      if (accept && req_kind == KIND_BUTTON && num_hi_zero) begin
         if (req_source_number[LINE_W-1:0] == cfg.up_line) begin
            flag_up_in = pressed;
         end else if (req_source_number[LINE_W-1:0] == cfg.down_line) begin
            flag_down_in = pressed;
         end else if (req_source_number[LINE_W-1:0] == cfg.left_line) begin
            flag_left_in = pressed;
         end else if (req_source_number[LINE_W-1:0] == cfg.right_line) begin
            flag_right_in = pressed;
         end
      end

      if (accept && req_kind == KIND_AXIS && num_hi_zero) begin
         if (req_source_number[LINE_W-1:0] == cfg.trigger_axis) begin
            if (trig_cnt_ff < CNT_W'(MAX_SAMPLES_PER_FRAME)) begin
               trig_sum_in = trig_sum_ff + sample_ext;
               trig_cnt_in = trig_cnt_ff + CNT_W'(1);
            end
         end else if (req_source_number[LINE_W-1:0] == cfg.calib_axis) begin
            if (cal_cnt_ff < CNT_W'(MAX_SAMPLES_PER_FRAME)) begin
               cal_sum_in = cal_sum_ff + sample_ext;
               cal_cnt_in = cal_cnt_ff + CNT_W'(1);
            end
         end
      end

      if (state_ff == ST_CAL_RUN && div_status.done && cal_cnt_ff != '0) begin
         offset_in = div_quotient[SAMPLE_W-1:0];
      end

      if (state_ff == ST_TRIG_RUN && div_status.done && trig_cnt_ff != '0) begin
         fire_in = above ^ cfg.invert_trigger;
      end

      if (load_out) begin
         trig_sum_in = '0;
         trig_cnt_in = '0;
         cal_sum_in  = '0;
         cal_cnt_in  = '0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      rsp_fire_in  = rsp_fire_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_fire_in  = fire_ff;
         dx_in = flag_left_ff ? DEFLECT_NEG : (flag_right_ff ? DEFLECT_POS : DEFLECT_NONE);
         dy_in = flag_up_ff ? DEFLECT_NEG : (flag_down_ff ? DEFLECT_POS : DEFLECT_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         flag_up_ff    <= 1'b0;
         flag_down_ff  <= 1'b0;
         flag_left_ff  <= 1'b0;
         flag_right_ff <= 1'b0;
         fire_ff       <= 1'b0;
         offset_ff     <= '0;
         trig_sum_ff   <= '0;
         trig_cnt_ff   <= '0;
         cal_sum_ff    <= '0;
         cal_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flag_up_ff    <= flag_up_in;
         flag_down_ff  <= flag_down_in;
         flag_left_ff  <= flag_left_in;
         flag_right_ff <= flag_right_in;
         fire_ff       <= fire_in;
         offset_ff     <= offset_in;
         trig_sum_ff   <= trig_sum_in;
         trig_cnt_ff   <= trig_cnt_in;
         cal_sum_ff    <= cal_sum_in;
         cal_cnt_ff    <= cal_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      rsp_fire_ff <= rsp_fire_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_delta_x = dx_ff;
   assign rsp_delta_y = dy_ff;
   assign rsp_fire    = rsp_fire_ff;

   `JEDT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      trig_cnt_ff <= CNT_W'(MAX_SAMPLES_PER_FRAME) && cal_cnt_ff <= CNT_W'(MAX_SAMPLES_PER_FRAME))
   `JEDT_ASSERT_NXT(a_tick_starts_div, clock, reset,
      accept && req_kind == KIND_TICK, state_ff == ST_CAL_RUN && div_status.busy)
   `JEDT_ASSERT_IMP(a_done_in_run, clock, reset, div_status.done,
      state_ff == ST_CAL_RUN || state_ff == ST_TRIG_RUN)

endmodule

// ----- rtl/core/jedt_csr.sv -----
// APB-style configuration register file for the joystick event block.
// Depends on jedt_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps

module jedt_csr
   import jedt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_UP_LINE:      cfg_in.up_line           = csr_pwdata[LINE_W-1:0];
            REG_DOWN_LINE:    cfg_in.down_line         = csr_pwdata[LINE_W-1:0];
            REG_LEFT_LINE:    cfg_in.left_line         = csr_pwdata[LINE_W-1:0];
            REG_RIGHT_LINE:   cfg_in.right_line        = csr_pwdata[LINE_W-1:0];
            REG_TRIGGER_AXIS: cfg_in.trigger_axis      = csr_pwdata[LINE_W-1:0];
            REG_CALIB_AXIS:   cfg_in.calib_axis        = csr_pwdata[LINE_W-1:0];
            REG_THRESHOLD:    cfg_in.trigger_threshold = $signed(csr_pwdata[THR_W-1:0]);
            REG_INVERT:       cfg_in.invert_trigger    = csr_pwdata[0];
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         REG_UP_LINE:      csr_prdata[LINE_W-1:0] = cfg_ff.up_line;
         REG_DOWN_LINE:    csr_prdata[LINE_W-1:0] = cfg_ff.down_line;
         REG_LEFT_LINE:    csr_prdata[LINE_W-1:0] = cfg_ff.left_line;
         REG_RIGHT_LINE:   csr_prdata[LINE_W-1:0] = cfg_ff.right_line;
         REG_TRIGGER_AXIS: csr_prdata[LINE_W-1:0] = cfg_ff.trigger_axis;
         REG_CALIB_AXIS:   csr_prdata[LINE_W-1:0] = cfg_ff.calib_axis;
         REG_THRESHOLD:    csr_prdata = {{(CSR_DW-THR_W){cfg_ff.trigger_threshold[THR_W-1]}},
                                         cfg_ff.trigger_threshold};
         REG_INVERT:       csr_prdata[0] = cfg_ff.invert_trigger;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/jedt_serial_div.sv -----
// Bit-serial signed-by-unsigned restoring divider, one quotient bit per cycle.
// Depends on jedt_pkg for the quotient width and the status struct.
`timescale 1ns / 1ps
`include "joystick_event_direction_trigger_top_macros.svh"

module jedt_serial_div
   import jedt_pkg::*;
#(
   parameter int SUM_W = 24,
   parameter int CNT_W = 8
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0]        divisor,
   output div_status_type          status,
   output logic signed [QUO_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;
   logic [QUO_W-1:0]  mag;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = dividend[SUM_W-1];
      end else if (busy_ff) begin
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign mag         = quo_ff[QUO_W-1:0];
   assign quotient    = neg_ff ? $signed(~mag + QUO_W'(1)) : $signed(mag);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `JEDT_ASSERT_IMP(a_no_restart, clock, reset, start, !busy_ff)
   `JEDT_ASSERT_IMP(a_done_idle, clock, reset, done_ff, !busy_ff)
   `JEDT_ASSERT_NXT(a_last_step, clock, reset,
      busy_ff && !start && step_ff == STEP_W'(SUM_W - 1), done_ff && !busy_ff)

endmodule
